// ===== src/chte_pkg.sv =====
`timescale 1ns / 1ps
package chte_pkg;

	localparam int BUCKET_COUNT = 256;
	localparam int ENTRY_COUNT  = 1024;
	localparam int VALUE_BITS   = 64;

	localparam int KEY_W  = 64;
	localparam int DATA_W = 64;
	localparam int LOC_W  = 10;
	localparam int IDX_W  = $clog2(ENTRY_COUNT);
	localparam int PTR_W  = IDX_W + 1;
	localparam int BKT_W  = $clog2(BUCKET_COUNT);

	localparam logic [PTR_W-1:0] PTR_NULL = {1'b1, {IDX_W{1'b0}}};

	localparam logic [1:0] ACT_INSERT = 2'd0;
	localparam logic [1:0] ACT_LOOKUP = 2'd1;
	localparam logic [1:0] ACT_DELETE = 2'd2;

	localparam logic [1:0] ST_DONE      = 2'd0;
	localparam logic [1:0] ST_UPDATED   = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [1:0] ST_FULL      = 2'd3;

	typedef struct packed {
		logic [1:0]        action;
		logic [KEY_W-1:0]  key;
		logic [DATA_W-1:0] value;
	} in_word_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [LOC_W-1:0]  location;
		logic [DATA_W-1:0] found_value;
	} out_word_t;

	typedef struct packed {
		logic                  we_key;
		logic                  we_value;
		logic                  we_next;
		logic [IDX_W-1:0]      addr;
		logic [KEY_W-1:0]      key;
		logic [VALUE_BITS-1:0] value;
		logic [PTR_W-1:0]      next;
	} ent_wr_t;

	typedef struct packed {
		logic [KEY_W-1:0]      key;
		logic [VALUE_BITS-1:0] value;
		logic [PTR_W-1:0]      next;
	} ent_rd_t;

	typedef struct packed {
		logic             we;
		logic [BKT_W-1:0] addr;
		logic [PTR_W-1:0] head;
	} bkt_wr_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_HEAD,
		S_WALK,
		S_ALLOC,
		S_DEL2,
		S_DONE
	} state_t;

	function automatic logic is_null(input logic [PTR_W-1:0] p);
		return p >= PTR_W'(ENTRY_COUNT);
	endfunction

endpackage

// ===== src/chte_bucket_mem.sv =====
`timescale 1ns / 1ps
module chte_bucket_mem (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      rd_en,
	input  logic [chte_pkg::BKT_W-1:0] rd_addr,
	output logic [chte_pkg::PTR_W-1:0] rd_head,
	input  chte_pkg::bkt_wr_t          wr
);

	logic [chte_pkg::PTR_W-1:0] mem [chte_pkg::BUCKET_COUNT];
	logic [chte_pkg::BUCKET_COUNT-1:0] vld_q;
	logic [chte_pkg::PTR_W-1:0] rd_q;
	logic rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr.addr] <= wr.head;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// A bucket never written since reset reads as an empty chain.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr.we) begin
				vld_q[wr.addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_head = rd_vld_q ? rd_q : chte_pkg::PTR_NULL;

endmodule

// ===== src/chte_entry_mem.sv =====
`timescale 1ns / 1ps
module chte_entry_mem (
	input  logic                      clk,
	input  logic                      rd_en,
	input  logic [chte_pkg::IDX_W-1:0] rd_addr,
	output chte_pkg::ent_rd_t          rd_data,
	input  chte_pkg::ent_wr_t          wr
);

	logic [chte_pkg::KEY_W-1:0]      key_mem   [chte_pkg::ENTRY_COUNT];
	logic [chte_pkg::VALUE_BITS-1:0] value_mem [chte_pkg::ENTRY_COUNT];
	logic [chte_pkg::PTR_W-1:0]      next_mem  [chte_pkg::ENTRY_COUNT];

	always_ff @(posedge clk) begin
		if (wr.we_key) begin
			key_mem[wr.addr] <= wr.key;
		end
		if (wr.we_value) begin
			value_mem[wr.addr] <= wr.value;
		end
		if (wr.we_next) begin
			next_mem[wr.addr] <= wr.next;
		end
		if (rd_en) begin
			rd_data.key   <= key_mem[rd_addr];
			rd_data.value <= value_mem[rd_addr];
			rd_data.next  <= next_mem[rd_addr];
		end
	end

endmodule

// ===== src/chte_ctrl.sv =====
`timescale 1ns / 1ps
module chte_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  chte_pkg::in_word_t          in_data,
	output logic                       out_valid,
	input  logic                       out_ready,
	output chte_pkg::out_word_t         out_data,
	output logic                       bkt_rd_en,
	output logic [chte_pkg::BKT_W-1:0]  bkt_rd_addr,
	input  logic [chte_pkg::PTR_W-1:0]  bkt_head,
	output chte_pkg::bkt_wr_t           bkt_wr,
	output logic                       ent_rd_en,
	output logic [chte_pkg::IDX_W-1:0]  ent_rd_addr,
	input  chte_pkg::ent_rd_t           ent_rd,
	output chte_pkg::ent_wr_t           ent_wr
);

	chte_pkg::state_t state_q, state_d;
	logic [1:0]                      act_q, act_d;
	logic [chte_pkg::KEY_W-1:0]      key_q, key_d;
	logic [chte_pkg::VALUE_BITS-1:0] val_q, val_d;
	logic [chte_pkg::PTR_W-1:0]      head_q, head_d;
	logic [chte_pkg::PTR_W-1:0]      cur_q, cur_d;
	logic [chte_pkg::PTR_W-1:0]      prev_q, prev_d;
	logic [chte_pkg::PTR_W-1:0]      free_q, free_d;
	logic [chte_pkg::PTR_W-1:0]      bump_q, bump_d;
	chte_pkg::out_word_t             res_q, res_d;
	chte_pkg::out_word_t             out_q;
	logic                            out_valid_q;
	logic                            load_out;
	logic                            miss, hit;
	logic                            ins_en;
	logic [chte_pkg::IDX_W-1:0]      ins_slot;
	logic [chte_pkg::PTR_W-1:0]      chain_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= chte_pkg::S_IDLE;
			free_q      <= chte_pkg::PTR_NULL;
			bump_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			free_q  <= free_d;
			bump_q  <= bump_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		act_q  <= act_d;
		key_q  <= key_d;
		val_q  <= val_d;
		head_q <= head_d;
		cur_q  <= cur_d;
		prev_q <= prev_d;
		res_q  <= res_d;
		if (load_out) begin
			out_q <= res_q;
		end
	end

	assign in_ready  = (state_q == chte_pkg::S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign bkt_rd_addr = in_data.key[chte_pkg::BKT_W-1:0];
	assign chain_head  = (state_q == chte_pkg::S_HEAD) ? bkt_head : head_q;

	always_comb begin
		state_d  = state_q;
		act_d    = act_q;
		key_d    = key_q;
		val_d    = val_q;
		head_d   = head_q;
		cur_d    = cur_q;
		prev_d   = prev_q;
		free_d   = free_q;
		bump_d   = bump_q;
		res_d    = res_q;
		load_out = 1'b0;
		miss     = 1'b0;
		hit      = 1'b0;
		ins_en   = 1'b0;
		ins_slot = '0;
		bkt_rd_en   = 1'b0;
		bkt_wr      = '0;
		ent_rd_en   = 1'b0;
		ent_rd_addr = '0;
		ent_wr      = '0;

		unique case (state_q)
			chte_pkg::S_IDLE: begin
				if (in_valid) begin
					act_d     = in_data.action;
					key_d     = in_data.key;
					val_d     = in_data.value[chte_pkg::VALUE_BITS-1:0];
					bkt_rd_en = 1'b1;
					state_d   = chte_pkg::S_HEAD;
				end
			end
			chte_pkg::S_HEAD: begin
				head_d = bkt_head;
				if (chte_pkg::is_null(bkt_head)) begin
					miss = 1'b1;
				end else begin
					ent_rd_en   = 1'b1;
					ent_rd_addr = bkt_head[chte_pkg::IDX_W-1:0];
					cur_d       = bkt_head;
					prev_d      = chte_pkg::PTR_NULL;
					state_d     = chte_pkg::S_WALK;
				end
			end
			chte_pkg::S_WALK: begin
				if (ent_rd.key == key_q) begin
					hit = 1'b1;
				end else begin
					prev_d = cur_q;
					cur_d  = ent_rd.next;
					if (chte_pkg::is_null(ent_rd.next)) begin
						miss = 1'b1;
					end else begin
						ent_rd_en   = 1'b1;
						ent_rd_addr = ent_rd.next[chte_pkg::IDX_W-1:0];
					end
				end
			end
			chte_pkg::S_ALLOC: begin
				// The popped free entry's link gives the new free-list head.
				free_d   = ent_rd.next;
				ins_en   = 1'b1;
				ins_slot = free_q[chte_pkg::IDX_W-1:0];
				state_d  = chte_pkg::S_DONE;
			end
			chte_pkg::S_DEL2: begin
				ent_wr.we_next = 1'b1;
				ent_wr.addr    = cur_q[chte_pkg::IDX_W-1:0];
				ent_wr.next    = free_q;
				free_d         = cur_q;
				state_d        = chte_pkg::S_DONE;
			end
			chte_pkg::S_DONE: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = chte_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = chte_pkg::S_IDLE;
			end
		endcase

		if (miss) begin
			res_d   = '{status: chte_pkg::ST_NOT_FOUND, location: '0, found_value: '0};
			state_d = chte_pkg::S_DONE;
			if (act_q == chte_pkg::ACT_INSERT) begin
				if (!chte_pkg::is_null(free_q)) begin
					ent_rd_en   = 1'b1;
					ent_rd_addr = free_q[chte_pkg::IDX_W-1:0];
					state_d     = chte_pkg::S_ALLOC;
				end else if (bump_q < chte_pkg::PTR_W'(chte_pkg::ENTRY_COUNT)) begin
					ins_en   = 1'b1;
					ins_slot = bump_q[chte_pkg::IDX_W-1:0];
					bump_d   = bump_q + 1'b1;
				end else begin
					res_d.status = chte_pkg::ST_FULL;
				end
			end
		end

		if (hit) begin
			state_d = chte_pkg::S_DONE;
			res_d   = '{status: chte_pkg::ST_NOT_FOUND, location: '0, found_value: '0};
			unique case (act_q)
				chte_pkg::ACT_LOOKUP: begin
					res_d.status      = chte_pkg::ST_DONE;
					res_d.location    = chte_pkg::LOC_W'(cur_q[chte_pkg::IDX_W-1:0]);
					res_d.found_value = chte_pkg::DATA_W'(ent_rd.value);
				end
				chte_pkg::ACT_INSERT: begin
					ent_wr.we_value = 1'b1;
					ent_wr.addr     = cur_q[chte_pkg::IDX_W-1:0];
					ent_wr.value    = val_q;
					res_d.status    = chte_pkg::ST_UPDATED;
					res_d.location  = chte_pkg::LOC_W'(cur_q[chte_pkg::IDX_W-1:0]);
				end
				chte_pkg::ACT_DELETE: begin
					res_d.status   = chte_pkg::ST_DONE;
					res_d.location = chte_pkg::LOC_W'(cur_q[chte_pkg::IDX_W-1:0]);
					if (chte_pkg::is_null(prev_q)) begin
						bkt_wr.we      = 1'b1;
						bkt_wr.addr    = key_q[chte_pkg::BKT_W-1:0];
						bkt_wr.head    = ent_rd.next;
						ent_wr.we_next = 1'b1;
						ent_wr.addr    = cur_q[chte_pkg::IDX_W-1:0];
						ent_wr.next    = free_q;
						free_d         = cur_q;
					end else begin
						// Unlink first; the freed entry is pushed next cycle.
						ent_wr.we_next = 1'b1;
						ent_wr.addr    = prev_q[chte_pkg::IDX_W-1:0];
						ent_wr.next    = ent_rd.next;
						state_d        = chte_pkg::S_DEL2;
					end
				end
				default: begin
				end
			endcase
		end

		if (ins_en) begin
			ent_wr.we_key   = 1'b1;
			ent_wr.we_value = 1'b1;
			ent_wr.we_next  = 1'b1;
			ent_wr.addr     = ins_slot;
			ent_wr.key      = key_q;
			ent_wr.value    = val_q;
			ent_wr.next     = chain_head;
			bkt_wr.we       = 1'b1;
			bkt_wr.addr     = key_q[chte_pkg::BKT_W-1:0];
			bkt_wr.head     = {1'b0, ins_slot};
			res_d.status    = chte_pkg::ST_DONE;
			res_d.location  = chte_pkg::LOC_W'(ins_slot);
			res_d.found_value = '0;
		end
	end

`ifndef SYNTH
	a_bump_range: assert property (@(posedge clk) disable iff (!arst_n)
		bump_q <= chte_pkg::PTR_W'(chte_pkg::ENTRY_COUNT))
		else $error("bump pointer beyond pool");

	a_free_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		free_q == chte_pkg::PTR_NULL || free_q < chte_pkg::PTR_W'(chte_pkg::ENTRY_COUNT))
		else $error("free-list head is not a valid entry");

	a_miss_loc: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == chte_pkg::S_DONE && (res_q.status == chte_pkg::ST_NOT_FOUND ||
		res_q.status == chte_pkg::ST_FULL)) |-> res_q.location == '0)
		else $error("location set on a miss or full result");
`endif

endmodule

// ===== src/chained_hash_table_engine_top.sv =====
`timescale 1ns / 1ps
// Separate-chaining hash table over a pool of 1024 entries and 256 buckets (bucket = low key
// bits). One word in gives one word out. A word passes from IDLE to HEAD, then stays in WALK
// while chain entries are read, then passes through ALLOC for an insert that reuses a freed
// entry or DEL2 for a delete of a non-head entry, and ends in DONE, which registers its result.
// The next word can be accepted in the cycle that the result is first offered. The chain walk
// through the entry memory, one read per cycle, sets how long a word takes. A result that
// the receiver has not taken holds the block in DONE. Bucket heads are empty straight after reset.
module chained_hash_table_engine_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  chte_pkg::in_word_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output chte_pkg::out_word_t out_data
);

	logic                       bkt_rd_en;
	logic [chte_pkg::BKT_W-1:0] bkt_rd_addr;
	logic [chte_pkg::PTR_W-1:0] bkt_head;
	chte_pkg::bkt_wr_t          bkt_wr;
	logic                       ent_rd_en;
	logic [chte_pkg::IDX_W-1:0] ent_rd_addr;
	chte_pkg::ent_rd_t          ent_rd;
	chte_pkg::ent_wr_t          ent_wr;

	chte_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
		.bkt_rd_en, .bkt_rd_addr, .bkt_head, .bkt_wr,
		.ent_rd_en, .ent_rd_addr, .ent_rd, .ent_wr
	);

	chte_bucket_mem u_bkt (
		.clk, .arst_n, .rd_en(bkt_rd_en), .rd_addr(bkt_rd_addr), .rd_head(bkt_head),
		.wr(bkt_wr)
	);

	chte_entry_mem u_ent (
		.clk, .rd_en(ent_rd_en), .rd_addr(ent_rd_addr), .rd_data(ent_rd), .wr(ent_wr)
	);

endmodule
